// ----- rtl/cdb_pkg.sv -----
// shared constants, opcodes and pointer helpers for the circular deque buffer
`timescale 1ns / 1ps

package cdb_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = 32;
    localparam int CFG_W = 11;
    localparam int OP_W  = 3;

    localparam int CAP_RESET_INT = (DEPTH < 1024) ? DEPTH : 1024;

    localparam logic [CW-1:0] CAP_RESET = CW'(CAP_RESET_INT);
    localparam logic [CW-1:0] CAP_MAX   = CW'(DEPTH);

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

    // clamp a written capacity into 1..DEPTH
    function automatic logic [CW-1:0] limit_cap(input logic [CFG_W-1:0] v);
        logic [CW-1:0] res;
        if (v == '0) begin
            res = CW'(1);
        end else if (32'(v) > 32'(DEPTH)) begin
            res = CAP_MAX;
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i,
                                              input logic [CW-1:0] cap);
        logic [CW:0]   nxt;
        logic [AW-1:0] res;
        nxt = (CW+1)'(i) + (CW+1)'(1);
        if (nxt >= (CW+1)'(cap)) begin
            res = '0;
        end else begin
            res = AW'(nxt);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [AW-1:0] res;
        if (i == '0 || (CW+1)'(i) > (CW+1)'(cap)) begin
            res = AW'(cap - CW'(1));
        end else begin
            res = i - AW'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/circular_deque_buffer_unit.sv -----
// top level of the circular deque buffer
`timescale 1ns / 1ps
//
// double-ended queue of 32-bit words in a ring memory of DEPTH entries
// request channel: i_in_valid / o_in_stall with i_opcode and i_value
//   opcodes: insert front, insert back, delete front, delete back, query
// result channel: o_out_valid / i_out_stall with ok, front and rear values
//   (-1 when empty) and the empty and full flags, one result per request
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_data as capacity
//   (0 taken as 1, above DEPTH taken as DEPTH); a write empties the deque
//   and the request channel stalls while a config write is offered
// timing: when a request is taken, pointers and the memory write update at
//   that edge and the read state follows; it reads front and rear from the
//   memory into its read registers and the flags into the result register
//   once that register is free; no request is taken during the read state
// a stalled result holds in its register; the next request is still taken
//   and waits in the read cycle until the result register frees up
// reset: capacity goes to min(1024, DEPTH), the deque is empty, memory
//   contents are not cleared and an empty deque shows -1, not memory words
//

module circular_deque_buffer_unit
    import cdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OP_W-1:0]        i_opcode,
    input  logic signed [DW-1:0]   i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_ok,
    output logic signed [DW-1:0]   o_front_value,
    output logic signed [DW-1:0]   o_rear_value,
    output logic                   o_is_empty,
    output logic                   o_is_full,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cap;
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [CW-1:0] r_occ, n_occ;
    logic          r_p_ok, n_ok;
    logic          r_out_valid;
    logic          r_o_ok;
    logic          r_o_empty;
    logic          r_o_full;

    logic          in_acc;
    logic          cfg_acc;
    logic          load;
    logic          full;
    logic          empty;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rear_addr;
    logic [DW-1:0] rd_front;
    logic [DW-1:0] rd_rear;

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign load        = (r_state == S_READ) && (!r_out_valid || !i_out_stall);

    assign full  = (r_occ >= r_cap);
    assign empty = (r_occ == '0);

    // operation decode and pointer update
    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_occ   = r_occ;
        n_ok    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = r_back;
        case (i_opcode)
            OP_INS_FRONT: begin
                if (!full) begin
                    n_front = step_down(r_front, r_cap);
                    wr_addr = n_front;
                    wr_en   = in_acc;
                    n_occ   = r_occ + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_INS_BACK: begin
                if (!full) begin
                    wr_addr = r_back;
                    wr_en   = in_acc;
                    n_back  = step_up(r_back, r_cap);
                    n_occ   = r_occ + CW'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_DEL_FRONT: begin
                if (!empty) begin
                    n_front = step_up(r_front, r_cap);
                    n_occ   = r_occ - CW'(1);
                    n_ok    = 1'b1;
                end
            end
            OP_DEL_BACK: begin
                if (!empty) begin
                    n_back = step_down(r_back, r_cap);
                    n_occ  = r_occ - CW'(1);
                    n_ok   = 1'b1;
                end
            end
            OP_QUERY: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign rear_addr = step_down(r_back, r_cap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RESET;
            r_front     <= '0;
            r_back      <= '0;
            r_occ       <= '0;
            r_p_ok      <= 1'b0;
            r_out_valid <= 1'b0;
            r_o_ok      <= 1'b0;
            r_o_empty   <= 1'b1;
            r_o_full    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_cap   <= limit_cap(i_cfg_data);
                r_front <= '0;
                r_back  <= '0;
                r_occ   <= '0;
            end else if (in_acc) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_occ   <= n_occ;
                r_p_ok  <= n_ok;
            end
            if (load) begin
                r_out_valid <= 1'b1;
                r_o_ok      <= r_p_ok;
                r_o_empty   <= empty;
                r_o_full    <= full;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    cdb_ring_mem u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_value),
        .i_rd_en     (load),
        .i_rd_addr_a (r_front),
        .i_rd_addr_b (rear_addr),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_rear)
    );

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_o_ok;
    assign o_is_empty    = r_o_empty;
    assign o_is_full     = r_o_full;
    assign o_front_value = r_o_empty ? '1 : rd_front;
    assign o_rear_value  = r_o_empty ? '1 : rd_rear;

endmodule

// ----- rtl/cdb_ring_mem.sv -----
// ring store: one write port, two registered read ports
`timescale 1ns / 1ps

module cdb_ring_mem
    import cdb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr_a,
    input  logic [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ----- sim/tb_circular_deque_buffer_unit.sv -----
// testbench for circular_deque_buffer_unit: directed table, biased random requests, predictor check
`timescale 1ns / 1ps

module tb_circular_deque_buffer_unit;
    import cdb_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam logic [DW-1:0]   NEG1      = 32'hFFFF_FFFF;
    localparam int              WATCHDOG_LIMIT = 2000;
    localparam int              PHASE_ITEMS    = 60;

    typedef struct packed {
        logic          ok;
        logic [DW-1:0] front;
        logic [DW-1:0] rear;
        logic          empty;
        logic          full;
    } t_deque_view;

    typedef struct packed {
        logic             is_cfg;
        logic [CFG_W-1:0] cfg;
        logic [OP_W-1:0]  op;
        logic [DW-1:0]    val;
        logic             typed;
        t_deque_view      want;
    } t_script_row;

    localparam t_deque_view VIEW_EMPTY_OK  = '{1'b1, NEG1, NEG1, 1'b1, 1'b0};
    localparam t_deque_view VIEW_EMPTY_BAD = '{1'b0, NEG1, NEG1, 1'b1, 1'b0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_opcode;
    logic signed [DW-1:0] i_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_ok;
    logic signed [DW-1:0] o_front_value;
    logic signed [DW-1:0] o_rear_value;
    logic                 o_is_empty;
    logic                 o_is_full;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_W-1:0]     i_cfg_data;

    // mirror of the deque
    logic [DW-1:0] ring_mirror [0:DEPTH-1];
    logic [AW-1:0] head_idx;
    logic [AW-1:0] tail_idx;
    logic [CW-1:0] fill_cnt;
    logic [CW-1:0] cap_now;

    t_deque_view awaited_views [$];
    t_script_row script [$];
    int          mismatch_count = 0;
    int          stall_left = 0;
    int          idle_cycles;
    logic        calm = 1'b0;

    logic [DW-1:0] corner_words [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    logic [CFG_W-1:0] phase_caps [10] = '{11'd1, 11'd2, 11'd3, 11'd7, 11'd16, 11'd1025,
                                          11'd64, 11'd1024, 11'd5, 11'd2047};

    circular_deque_buffer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_front_value (o_front_value),
        .o_rear_value  (o_rear_value),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        if (int'(i) + 1 >= int'(cap_now)) begin
            return '0;
        end
        return i + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
        if (i == '0) begin
            return AW'(cap_now - CW'(1));
        end
        return i - AW'(1);
    endfunction

    function automatic t_deque_view apply_deque_op(input logic [OP_W-1:0] op,
                                                   input logic [DW-1:0] val);
        t_deque_view v;
        logic        was_full;
        logic        was_empty;
        was_full  = (fill_cnt >= cap_now);
        was_empty = (fill_cnt == '0);
        v.ok = 1'b0;
        case (op)
            OP_INS_FRONT: begin
                if (!was_full) begin
                    head_idx = ring_prev(head_idx);
                    ring_mirror[head_idx] = val;
                    fill_cnt = fill_cnt + CW'(1);
                    v.ok = 1'b1;
                end
            end
            OP_INS_BACK: begin
                if (!was_full) begin
                    ring_mirror[tail_idx] = val;
                    tail_idx = ring_next(tail_idx);
                    fill_cnt = fill_cnt + CW'(1);
                    v.ok = 1'b1;
                end
            end
            OP_DEL_FRONT: begin
                if (!was_empty) begin
                    head_idx = ring_next(head_idx);
                    fill_cnt = fill_cnt - CW'(1);
                    v.ok = 1'b1;
                end
            end
            OP_DEL_BACK: begin
                if (!was_empty) begin
                    tail_idx = ring_prev(tail_idx);
                    fill_cnt = fill_cnt - CW'(1);
                    v.ok = 1'b1;
                end
            end
            OP_QUERY: begin
                v.ok = 1'b1;
            end
            default: begin
            end
        endcase
        v.empty = (fill_cnt == '0);
        v.full  = (fill_cnt >= cap_now);
        v.front = v.empty ? NEG1 : ring_mirror[head_idx];
        v.rear  = v.empty ? NEG1 : ring_mirror[ring_prev(tail_idx)];
        return v;
    endfunction

    task automatic issue_request(input logic [OP_W-1:0] op, input logic [DW-1:0] val,
                                 input logic typed, input t_deque_view want);
        int          gap;
        t_deque_view predicted;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_deque_op(op, val);
        awaited_views.push_back(typed ? want : predicted);
    endtask

    task automatic load_capacity(input logic [CFG_W-1:0] data);
        i_in_valid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (data == '0) begin
            cap_now = CW'(1);
        end else if (int'(data) > DEPTH) begin
            cap_now = CW'(DEPTH);
        end else begin
            cap_now = CW'(data);
        end
        head_idx = '0;
        tail_idx = '0;
        fill_cnt = '0;
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (got !== want) begin
            $error("%s expected %h got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // result side: random stall, compare against the oldest request
    always @(posedge i_clk) begin
        t_deque_view want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_views.size() == 0) begin
                    $error("result with no request pending");
                    mismatch_count++;
                end else begin
                    want = awaited_views.pop_front();
                    check_field("ok", DW'(want.ok), DW'(o_ok));
                    check_field("front_value", want.front, o_front_value);
                    check_field("rear_value", want.rear, o_rear_value);
                    check_field("is_empty", DW'(want.empty), DW'(o_is_empty));
                    check_field("is_full", DW'(want.full), DW'(o_is_full));
                end
                stall_left = draw_wait();
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [OP_W-1:0] op;
        logic [DW-1:0]   val;
        logic            filling;
        int              roll;
        int              sent;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_QUERY;
        i_value     <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        head_idx = '0;
        tail_idx = '0;
        fill_cnt = '0;
        cap_now  = CW'(DEPTH);

        // is_cfg, cfg, op, value, typed, expected
        script.push_back('{1'b0, 11'd0, OP_QUERY, 32'd0, 1'b1, VIEW_EMPTY_OK});
        script.push_back('{1'b0, 11'd0, OP_DEL_FRONT, 32'd0, 1'b1, VIEW_EMPTY_BAD});
        script.push_back('{1'b0, 11'd0, OP_DEL_BACK, 32'd0, 1'b1, VIEW_EMPTY_BAD});
        script.push_back('{1'b0, 11'd0, OP_RSVD_7, 32'd0, 1'b1, VIEW_EMPTY_BAD});
        script.push_back('{1'b0, 11'd0, OP_INS_BACK, 32'h7FFF_FFFF, 1'b1,
                           '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}});
        // front index wraps below zero
        script.push_back('{1'b0, 11'd0, OP_INS_FRONT, 32'h8000_0000, 1'b1,
                           '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}});
        script.push_back('{1'b0, 11'd0, OP_INS_BACK, 32'hFFFF_FFFF, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_INS_FRONT, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_RSVD_5, 32'h1234_5678, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_RSVD_6, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_DEL_BACK, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_DEL_FRONT, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_DEL_BACK, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_DEL_FRONT, 32'h0, 1'b1, VIEW_EMPTY_OK});
        // zero capacity is taken as one
        script.push_back('{1'b1, 11'd0, OP_QUERY, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_QUERY, 32'h0, 1'b1, VIEW_EMPTY_OK});
        script.push_back('{1'b0, 11'd0, OP_INS_BACK, 32'h1234_5678, 1'b1,
                           '{1'b1, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1}});
        script.push_back('{1'b0, 11'd0, OP_INS_FRONT, 32'h5555_5555, 1'b1,
                           '{1'b0, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1}});
        script.push_back('{1'b0, 11'd0, OP_INS_BACK, 32'hAAAA_AAAA, 1'b1,
                           '{1'b0, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1}});
        script.push_back('{1'b0, 11'd0, OP_DEL_FRONT, 32'h0, 1'b1, VIEW_EMPTY_OK});
        script.push_back('{1'b0, 11'd0, OP_INS_FRONT, 32'hAAAA_AAAA, 1'b1,
                           '{1'b1, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, 1'b1}});
        script.push_back('{1'b0, 11'd0, OP_DEL_BACK, 32'h0, 1'b1, VIEW_EMPTY_OK});
        // capacity above the store size is taken as the store size
        script.push_back('{1'b1, 11'd2047, OP_QUERY, 32'h0, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_INS_FRONT, 32'h1, 1'b0, '0});
        script.push_back('{1'b0, 11'd0, OP_QUERY, 32'h0, 1'b0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                load_capacity(script[k].cfg);
            end else begin
                issue_request(script[k].op, script[k].val, script[k].typed, script[k].want);
            end
        end

        foreach (phase_caps[p]) begin
            load_capacity(phase_caps[p]);
            calm    = ($urandom_range(0, 3) == 0);
            filling = 1'b1;
            sent    = 0;
            while (sent < PHASE_ITEMS) begin
                if (fill_cnt >= cap_now) begin
                    filling = 1'b0;
                end else if (fill_cnt == '0) begin
                    filling = 1'b1;
                end else if ($urandom_range(0, 49) == 0) begin
                    filling = !filling;
                end
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    op = OP_RSVD_5 + OP_W'($urandom_range(0, 2));
                end else if (roll < 12) begin
                    op = OP_QUERY;
                end else if ((roll < 80) == filling) begin
                    op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
                end else begin
                    op = $urandom_range(0, 1) ? OP_DEL_BACK : OP_DEL_FRONT;
                end
                val = ($urandom_range(0, 9) == 0) ? corner_words[$urandom_range(0, 3)]
                                                  : $urandom;
                issue_request(op, val, 1'b0, '0);
                if (op <= OP_QUERY) begin
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        while (awaited_views.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cdb_pkg.sv
rtl/cdb_ring_mem.sv
rtl/circular_deque_buffer_unit.sv
sim/tb_circular_deque_buffer_unit.sv
